>>> rtl/core/rwi_pkg.sv
// ----------------------------------------------------------------------------
// rwi_pkg: shared types and constants for the ray against wall intersection
// Holds the stage counts of the divider and square root pipelines and the
// sideband records that travel alongside their datapaths.
// ----------------------------------------------------------------------------
package rwi_pkg;

  // Restoring divider: one precheck stage plus one quotient bit per stage.
  localparam int DIV_STEPS = 34;
  localparam int DIV_N_W   = 101;
  localparam int DIV_D_W   = 67;

  // Square root: one result bit per stage.
  localparam int SQ_STEPS  = 32;
  localparam int SQ_X_W    = 64;
  localparam int SQ_REM_W  = 35;

  // Fields that ride along with the two divider lanes.
  typedef struct packed {
    logic               xneg;
    logic               yneg;
    logic               zero;
    logic signed [32:0] wx;
    logic signed [32:0] wy;
    logic signed [31:0] w1x;
    logic signed [31:0] w1y;
    logic        [31:0] len;
  } div_sb_t;

  // Fields that ride along with the square root.
  typedef struct packed {
    logic               miss;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic        [31:0] len;
  } sq_sb_t;

endpackage

>>> rtl/core/rwi_div.sv
// ----------------------------------------------------------------------------
// rwi_div: two-lane pipelined restoring divider
// Computes floor(N / D) for two numerators over one shared divisor, one
// quotient bit per stage. A precheck flags quotients of 2^34 or more.
// ----------------------------------------------------------------------------
module rwi_div
  import rwi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [DIV_N_W-1:0]   in_nx,
  input  logic [DIV_N_W-1:0]   in_ny,
  input  logic [DIV_D_W-1:0]   in_d,
  input  div_sb_t              in_sb,
  output logic                 out_valid,
  output logic [DIV_STEPS-1:0] out_qx,
  output logic [DIV_STEPS-1:0] out_qy,
  output logic                 out_bigx,
  output logic                 out_bigy,
  output div_sb_t              out_sb
);

  logic [DIV_STEPS:0]   v_r;
  logic [DIV_N_W-1:0]   remx_r [0:DIV_STEPS];
  logic [DIV_N_W-1:0]   remy_r [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] qx_r   [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] qy_r   [0:DIV_STEPS];
  logic [DIV_D_W-1:0]   d_r    [0:DIV_STEPS];
  logic                 bigx_r [0:DIV_STEPS];
  logic                 bigy_r [0:DIV_STEPS];
  div_sb_t              sb_r   [0:DIV_STEPS];

  // Precheck stage: the quotient overflows when N >= D * 2^34.
  always_ff @(posedge clk) begin
    if (en) begin
      remx_r[0] <= in_nx;
      remy_r[0] <= in_ny;
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      d_r[0]    <= in_d;
      bigx_r[0] <= in_nx >= {in_d, {DIV_STEPS{1'b0}}};
      bigy_r[0] <= in_ny >= {in_d, {DIV_STEPS{1'b0}}};
      sb_r[0]   <= in_sb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [DIV_N_W-1:0] trial;
    logic               gex;
    logic               gey;

    assign trial = DIV_N_W'(d_r[s]) << (DIV_STEPS - 1 - s);
    assign gex   = remx_r[s] >= trial;
    assign gey   = remy_r[s] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        remx_r[s+1] <= gex ? remx_r[s] - trial : remx_r[s];
        remy_r[s+1] <= gey ? remy_r[s] - trial : remy_r[s];
        qx_r[s+1]   <= {qx_r[s][DIV_STEPS-2:0], gex};
        qy_r[s+1]   <= {qy_r[s][DIV_STEPS-2:0], gey};
        d_r[s+1]    <= d_r[s];
        bigx_r[s+1] <= bigx_r[s];
        bigy_r[s+1] <= bigy_r[s];
        sb_r[s+1]   <= sb_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end
  end

  assign out_valid = v_r[DIV_STEPS];
  assign out_qx    = qx_r[DIV_STEPS];
  assign out_qy    = qy_r[DIV_STEPS];
  assign out_bigx  = bigx_r[DIV_STEPS];
  assign out_bigy  = bigy_r[DIV_STEPS];
  assign out_sb    = sb_r[DIV_STEPS];

endmodule

>>> rtl/core/rwi_isqrt.sv
// ----------------------------------------------------------------------------
// rwi_isqrt: pipelined integer square root
// Computes floor(sqrt(x)) of a 64-bit value, one result bit per stage,
// with a sideband record carried alongside.
// ----------------------------------------------------------------------------
module rwi_isqrt
  import rwi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_X_W-1:0] in_x,
  input  sq_sb_t            in_sb,
  output logic              out_valid,
  output logic [31:0]       out_root,
  output sq_sb_t            out_sb
);

  logic [SQ_STEPS:0]     v_r;
  logic [SQ_X_W-1:0]     x_r    [0:SQ_STEPS];
  logic [SQ_REM_W-1:0]   rem_r  [0:SQ_STEPS];
  logic [31:0]           root_r [0:SQ_STEPS];
  sq_sb_t                sb_r   [0:SQ_STEPS];

  // Stage zero entry values come straight from the ports.
  assign v_r[0]    = in_valid;
  assign x_r[0]    = in_x;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign sb_r[0]   = in_sb;

  // Each stage brings down two bits of x and decides one root bit.
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic [SQ_REM_W-1:0] rem_sh;
    logic [SQ_REM_W-1:0] trial;
    logic                ge;

    assign rem_sh = {rem_r[k][SQ_REM_W-3:0], x_r[k][SQ_X_W-1 -: 2]};
    assign trial  = {1'b0, root_r[k], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k+1]    <= {x_r[k][SQ_X_W-3:0], 2'b00};
        rem_r[k+1]  <= ge ? rem_sh - trial : rem_sh;
        root_r[k+1] <= {root_r[k][30:0], ge};
        sb_r[k+1]   <= sb_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end
  end

  assign out_valid = v_r[SQ_STEPS];
  assign out_root  = root_r[SQ_STEPS];
  assign out_sb    = sb_r[SQ_STEPS];

endmodule

>>> rtl/core/ray_wall_intersection.sv
// ----------------------------------------------------------------------------
// ray_wall_intersection: ray line against wall segment intersection
// Intersects the infinite line through two ray points with a wall segment
// and reports the crossing point and the column offset along the wall.
// ----------------------------------------------------------------------------
// Usage:
// An item enters on the in_ stream: the ray's two points, the wall's two
// endpoints and the stored wall length, all Q16.16. Each item gives exactly
// one result on the out_ stream: a hit flag, the crossing point and the
// column offset (distance from the wall start minus half the wall length).
// On a miss the crossing reads as minus one and the offset as zero.
// The pipeline takes one item per clock while in_tready is high; most of its
// depth comes from the 34-step quotient pipeline and the 32-step square root
// pipeline, one bit per stage each. When the receiver stalls, one more result
// is caught in a skid register and the whole pipeline then holds; in_tready
// follows that skid register, and nothing is lost or repeated. Reset empties
// all stages and both output registers; no configuration is needed.
// ----------------------------------------------------------------------------
module ray_wall_intersection
  import rwi_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // ray_start_x, ray_start_y, ray_end_x, ray_end_y, wall_start_x,
  // wall_start_y, wall_end_x, wall_end_y, wall_length (32 bits each)
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // hit (1), cross_x (32), cross_y (32), column_offset (32), zero pad (7)
  output logic [103:0] out_tdata
);

  localparam logic [DIV_STEPS-1:0] FAR_Q = {1'b0, {(DIV_STEPS-1){1'b1}}};

  // Saturate a 34-bit signed sum to the signed 32-bit range.
  function automatic logic signed [31:0] clamp32(input logic signed [33:0] v);
    logic [2:0] top;
    top = v[33:31];
    if (top == 3'b000 || top == 3'b111) begin
      return v[31:0];
    end else if (v[33]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

  logic adv;
  logic skid_v_r;
  logic out_v_r;
  logic [96:0] out_data_r;
  logic [96:0] skid_data_r;

  assign adv       = !skid_v_r;
  assign in_tready = adv;

  // Input fields.
  logic signed [31:0] sx, sy, ex, ey, w1x, w1y, w2x, w2y;
  logic        [31:0] len_in;

  assign sx     = in_tdata[31:0];
  assign sy     = in_tdata[63:32];
  assign ex     = in_tdata[95:64];
  assign ey     = in_tdata[127:96];
  assign w1x    = in_tdata[159:128];
  assign w1y    = in_tdata[191:160];
  assign w2x    = in_tdata[223:192];
  assign w2y    = in_tdata[255:224];
  assign len_in = in_tdata[287:256];

  // Stage 1: direction and offset vectors.
  logic               s1_v_r;
  logic signed [32:0] s1_rx_r, s1_ry_r, s1_wx_r, s1_wy_r, s1_qx_r, s1_qy_r;
  logic signed [31:0] s1_w1x_r, s1_w1y_r;
  logic        [31:0] s1_len_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rx_r  <= {ex[31], ex} - {sx[31], sx};
      s1_ry_r  <= {ey[31], ey} - {sy[31], sy};
      s1_wx_r  <= {w2x[31], w2x} - {w1x[31], w1x};
      s1_wy_r  <= {w2y[31], w2y} - {w1y[31], w1y};
      s1_qx_r  <= {w1x[31], w1x} - {sx[31], sx};
      s1_qy_r  <= {w1y[31], w1y} - {sy[31], sy};
      s1_w1x_r <= w1x;
      s1_w1y_r <= w1y;
      s1_len_r <= len_in;
    end
  end

  // Stage 2: the four cross product terms.
  logic               s2_v_r;
  logic signed [65:0] s2_p1_r, s2_p2_r, s2_p3_r, s2_p4_r;
  logic signed [32:0] s2_wx_r, s2_wy_r;
  logic signed [31:0] s2_w1x_r, s2_w1y_r;
  logic        [31:0] s2_len_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_p1_r  <= s1_rx_r * s1_qy_r;
      s2_p2_r  <= s1_ry_r * s1_qx_r;
      s2_p3_r  <= s1_wx_r * s1_ry_r;
      s2_p4_r  <= s1_wy_r * s1_rx_r;
      s2_wx_r  <= s1_wx_r;
      s2_wy_r  <= s1_wy_r;
      s2_w1x_r <= s1_w1x_r;
      s2_w1y_r <= s1_w1y_r;
      s2_len_r <= s1_len_r;
    end
  end

  // Stage 3: numerator cross(r,q) and denominator cross(w,r).
  logic               s3_v_r;
  logic signed [66:0] s3_num_r, s3_den_r;
  logic signed [32:0] s3_wx_r, s3_wy_r;
  logic signed [31:0] s3_w1x_r, s3_w1y_r;
  logic        [31:0] s3_len_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_num_r <= {s2_p1_r[65], s2_p1_r} - {s2_p2_r[65], s2_p2_r};
      s3_den_r <= {s2_p3_r[65], s2_p3_r} - {s2_p4_r[65], s2_p4_r};
      s3_wx_r  <= s2_wx_r;
      s3_wy_r  <= s2_wy_r;
      s3_w1x_r <= s2_w1x_r;
      s3_w1y_r <= s2_w1y_r;
      s3_len_r <= s2_len_r;
    end
  end

  // Stage 4: magnitudes and result signs.
  logic          s4_v_r;
  logic [66:0]   s4_nm_r, s4_dm_r;
  logic [32:0]   s4_awx_r, s4_awy_r;
  div_sb_t       s4_sb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_nm_r      <= s3_num_r[66] ? 67'(0 - s3_num_r) : s3_num_r;
      s4_dm_r      <= s3_den_r[66] ? 67'(0 - s3_den_r) : s3_den_r;
      s4_awx_r     <= s3_wx_r[32] ? 33'(0 - s3_wx_r) : s3_wx_r;
      s4_awy_r     <= s3_wy_r[32] ? 33'(0 - s3_wy_r) : s3_wy_r;
      s4_sb_r.xneg <= s3_wx_r[32] ^ s3_num_r[66] ^ s3_den_r[66];
      s4_sb_r.yneg <= s3_wy_r[32] ^ s3_num_r[66] ^ s3_den_r[66];
      s4_sb_r.zero <= s3_den_r == '0;
      s4_sb_r.wx   <= s3_wx_r;
      s4_sb_r.wy   <= s3_wy_r;
      s4_sb_r.w1x  <= s3_w1x_r;
      s4_sb_r.w1y  <= s3_w1y_r;
      s4_sb_r.len  <= s3_len_r;
    end
  end

  // Stage 5: partial products of the numerator magnitude, 23-bit slices.
  logic        s5_v_r;
  logic [68:0] nm_ext;
  logic [55:0] s5_px_r [0:2];
  logic [55:0] s5_py_r [0:2];
  logic [66:0] s5_dm_r;
  div_sb_t     s5_sb_r;

  assign nm_ext = {2'b00, s4_nm_r};

  for (genvar k = 0; k < 3; k++) begin : g_pp
    always_ff @(posedge clk) begin
      if (adv) begin
        s5_px_r[k] <= nm_ext[23*k +: 23] * s4_awx_r;
        s5_py_r[k] <= nm_ext[23*k +: 23] * s4_awy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_dm_r <= s4_dm_r;
      s5_sb_r <= s4_sb_r;
    end
  end

  // Stage 6: sum the slices and double, for a quotient with one extra bit.
  logic               s6_v_r;
  logic [DIV_N_W-1:0] s6_nx_r, s6_ny_r;
  logic [66:0]        s6_dm_r;
  div_sb_t            s6_sb_r;
  logic [99:0]        prodx, prody;

  assign prodx = 100'(s5_px_r[0]) + (100'(s5_px_r[1]) << 23) + (100'(s5_px_r[2]) << 46);
  assign prody = 100'(s5_py_r[0]) + (100'(s5_py_r[1]) << 23) + (100'(s5_py_r[2]) << 46);

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_nx_r <= {prodx, 1'b0};
      s6_ny_r <= {prody, 1'b0};
      s6_dm_r <= s5_dm_r;
      s6_sb_r <= s5_sb_r;
    end
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_tvalid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
    end
  end

  // Quotients of twice the scaled numerator over the denominator.
  logic                 dv_v;
  logic [DIV_STEPS-1:0] dv_qx, dv_qy;
  logic                 dv_bigx, dv_bigy;
  div_sb_t              dv_sb;

  rwi_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s6_v_r),
    .in_nx     (s6_nx_r),
    .in_ny     (s6_ny_r),
    .in_d      (s6_dm_r),
    .in_sb     (s6_sb_r),
    .out_valid (dv_v),
    .out_qx    (dv_qx),
    .out_qy    (dv_qy),
    .out_bigx  (dv_bigx),
    .out_bigy  (dv_bigy),
    .out_sb    (dv_sb)
  );

  // T1: round half away from zero; flag zero denominators and offsets of 2^32 or more.
  logic               t1_v_r;
  logic [34:0]        qx1, qy1;
  logic [31:0]        t1_omx_r, t1_omy_r;
  logic               t1_miss_r;
  div_sb_t            t1_sb_r;

  assign qx1 = 35'(dv_qx) + 35'd1;
  assign qy1 = 35'(dv_qy) + 35'd1;

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_omx_r  <= qx1[32:1];
      t1_omy_r  <= qy1[32:1];
      t1_miss_r <= dv_sb.zero || dv_bigx || dv_bigy || (dv_qx >= FAR_Q) || (dv_qy >= FAR_Q);
      t1_sb_r   <= dv_sb;
    end
  end

  // T2: signed offsets, squared offset magnitudes and squared length.
  logic               t2_v_r;
  logic signed [32:0] t2_ox_r, t2_oy_r;
  logic        [63:0] t2_sqx_r, t2_sqy_r, t2_l2_r;
  logic               t2_miss_r;
  div_sb_t            t2_sb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_ox_r   <= t1_sb_r.xneg ? 33'(0 - {1'b0, t1_omx_r}) : {1'b0, t1_omx_r};
      t2_oy_r   <= t1_sb_r.yneg ? 33'(0 - {1'b0, t1_omy_r}) : {1'b0, t1_omy_r};
      t2_sqx_r  <= t1_omx_r * t1_omx_r;
      t2_sqy_r  <= t1_omy_r * t1_omy_r;
      t2_l2_r   <= t1_sb_r.len * t1_sb_r.len;
      t2_miss_r <= t1_miss_r;
      t2_sb_r   <= t1_sb_r;
    end
  end

  // T3: squared distance to the start, offset from the end, crossing point.
  logic               t3_v_r;
  logic        [64:0] t3_d1_r;
  logic signed [33:0] t3_dx_r, t3_dy_r, t3_cx_r, t3_cy_r;
  logic        [63:0] t3_l2_r;
  logic               t3_miss_r;
  logic        [31:0] t3_len_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      t3_d1_r   <= 65'(t2_sqx_r) + 65'(t2_sqy_r);
      t3_dx_r   <= {t2_ox_r[32], t2_ox_r} - {t2_sb_r.wx[32], t2_sb_r.wx};
      t3_dy_r   <= {t2_oy_r[32], t2_oy_r} - {t2_sb_r.wy[32], t2_sb_r.wy};
      t3_cx_r   <= {{2{t2_sb_r.w1x[31]}}, t2_sb_r.w1x} + {t2_ox_r[32], t2_ox_r};
      t3_cy_r   <= {{2{t2_sb_r.w1y[31]}}, t2_sb_r.w1y} + {t2_oy_r[32], t2_oy_r};
      t3_l2_r   <= t2_l2_r;
      t3_miss_r <= t2_miss_r;
      t3_len_r  <= t2_sb_r.len;
    end
  end

  // T4: start distance test, end offset magnitudes, saturated crossing.
  logic               t4_v_r;
  logic        [33:0] t4_adx_r, t4_ady_r;
  logic        [63:0] t4_d1_r, t4_l2_r;
  logic signed [31:0] t4_cx_r, t4_cy_r;
  logic               t4_miss_r;
  logic        [31:0] t4_len_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      t4_adx_r  <= t3_dx_r[33] ? 34'(0 - t3_dx_r) : t3_dx_r;
      t4_ady_r  <= t3_dy_r[33] ? 34'(0 - t3_dy_r) : t3_dy_r;
      t4_miss_r <= t3_miss_r || (t3_d1_r > {1'b0, t3_l2_r});
      t4_d1_r   <= t3_d1_r[63:0];
      t4_l2_r   <= t3_l2_r;
      t4_cx_r   <= clamp32(t3_cx_r);
      t4_cy_r   <= clamp32(t3_cy_r);
      t4_len_r  <= t3_len_r;
    end
  end

  // T5: squares of the end offset.
  logic        t5_v_r;
  logic [67:0] t5_s2x_r, t5_s2y_r;
  logic [63:0] t5_d1_r, t5_l2_r;
  sq_sb_t      t5_sb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      t5_s2x_r     <= t4_adx_r * t4_adx_r;
      t5_s2y_r     <= t4_ady_r * t4_ady_r;
      t5_d1_r      <= t4_d1_r;
      t5_l2_r      <= t4_l2_r;
      t5_sb_r.miss <= t4_miss_r;
      t5_sb_r.cx   <= t4_cx_r;
      t5_sb_r.cy   <= t4_cy_r;
      t5_sb_r.len  <= t4_len_r;
    end
  end

  // T6: end distance test.
  logic        t6_v_r;
  logic [63:0] t6_d1_r;
  sq_sb_t      t6_sb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      t6_d1_r <= t5_d1_r;
      t6_sb_r <= '{miss: t5_sb_r.miss ||
                         ((69'(t5_s2x_r) + 69'(t5_s2y_r)) > 69'(t5_l2_r)),
                   cx:   t5_sb_r.cx,
                   cy:   t5_sb_r.cy,
                   len:  t5_sb_r.len};
    end
  end

  // Valid bits of the back stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
      t2_v_r <= 1'b0;
      t3_v_r <= 1'b0;
      t4_v_r <= 1'b0;
      t5_v_r <= 1'b0;
      t6_v_r <= 1'b0;
    end else if (adv) begin
      t1_v_r <= dv_v;
      t2_v_r <= t1_v_r;
      t3_v_r <= t2_v_r;
      t4_v_r <= t3_v_r;
      t5_v_r <= t4_v_r;
      t6_v_r <= t5_v_r;
    end
  end

  // Distance from the wall start as the root of the squared distance.
  logic        sq_v;
  logic [31:0] sq_root;
  sq_sb_t      sq_sb;

  rwi_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (t6_v_r),
    .in_x      (t6_d1_r),
    .in_sb     (t6_sb_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_sb    (sq_sb)
  );

  // Final result record: hit, cross_x, cross_y, column_offset.
  logic [96:0] res;
  logic [31:0] col;

  assign col = sq_root - {1'b0, sq_sb.len[31:1]};
  assign res = sq_sb.miss ? {32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}
                          : {col, sq_sb.cy, sq_sb.cx, 1'b1};

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_tready) begin
      if (adv && sq_v) begin
        skid_v_r <= 1'b1;
      end
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && !out_tready) begin
      if (adv && sq_v) begin
        skid_data_r <= res;
      end
    end else if (skid_v_r) begin
      out_data_r <= skid_data_r;
    end else begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'b0, out_data_r};

  // The skid entry is only ever occupied behind a held output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry valid while output register empty");

  // The skid entry fills only when the output was stalled.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready))
    else $error("skid entry filled without a stalled output");

  // A miss always carries the fixed miss values in the other fields.
  a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_data_r[0]) |->
      (out_data_r[96:1] == {32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}))
    else $error("miss result with unexpected field values");

endmodule

>>> sim/rwi_checker.sv
// ----------------------------------------------------------------------------
// rwi_checker: scoreboard for the ray against wall intersection
// Watches both streams, computes the expected crossing for every accepted
// input transfer and compares each output transfer with the oldest one.
// ----------------------------------------------------------------------------
module rwi_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [287:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [103:0] out_tdata,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic               hit;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] col;
  } crossing_t;

  crossing_t crossings_due[$];

  // Integer square root of a 64-bit value, floor.
  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Offset along one wall axis: round(wc * num / den), ties away from zero.
  // Returns 0 in ok when the magnitude reaches 2^32.
  function automatic logic signed [63:0] wall_offset(logic signed [33:0] wc,
      logic signed [127:0] num, logic signed [127:0] den, output bit ok);
    logic [127:0] nm, dm, prod, q, r;
    logic [33:0]  um;
    logic signed [63:0] v;
    nm   = num[127] ? -num : num;
    dm   = den[127] ? -den : den;
    um   = wc[33] ? -wc : wc;
    prod = nm * um;
    q    = prod / dm;
    r    = prod % dm;
    if ((r << 1) >= dm) q = q + 1;
    ok = (q < 128'h1_0000_0000);
    v  = $signed({32'd0, q[31:0]});
    if (wc[33] ^ num[127] ^ den[127]) v = -v;
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic crossing_t predict_crossing(logic [287:0] d);
    logic signed [63:0]  sx, sy, ex, ey, w1x, w1y, w2x, w2y;
    logic signed [63:0]  rx, ry, wx, wy, qx, qy, ox, oy, ax, ay;
    logic signed [127:0] num, den;
    logic [127:0]        l2, d1, d2;
    logic [31:0]         len;
    bit                  okx, oky;
    crossing_t           c;
    sx  = $signed(d[31:0]);    sy  = $signed(d[63:32]);
    ex  = $signed(d[95:64]);   ey  = $signed(d[127:96]);
    w1x = $signed(d[159:128]); w1y = $signed(d[191:160]);
    w2x = $signed(d[223:192]); w2y = $signed(d[255:224]);
    len = d[287:256];
    rx = ex - sx;   ry = ey - sy;
    wx = w2x - w1x; wy = w2y - w1y;
    qx = w1x - sx;  qy = w1y - sy;
    num = 128'(rx) * 128'(qy) - 128'(ry) * 128'(qx);
    den = 128'(wx) * 128'(ry) - 128'(wy) * 128'(rx);
    c = '{hit: 1'b0, cx: -32'sd1, cy: -32'sd1, col: 32'sd0};
    l2 = 128'(len) * 128'(len);
    if (den == 0) return c;
    ox = wall_offset(wx[33:0], num, den, okx);
    oy = wall_offset(wy[33:0], num, den, oky);
    if (!okx || !oky) return c;
    d1 = 128'(ox) * 128'(ox) + 128'(oy) * 128'(oy);
    ax = ox - wx; ay = oy - wy;
    d2 = 128'($signed(128'(ax)) * $signed(128'(ax))) +
         128'($signed(128'(ay)) * $signed(128'(ay)));
    if (d1 > l2 || d2 > l2) return c;
    c.hit = 1'b1;
    c.cx  = sat32(w1x + ox);
    c.cy  = sat32(w1y + oy);
    c.col = 32'(isqrt(d1[63:0]) - 64'(len >> 1));
    return c;
  endfunction

  // Predict on every input transfer, compare on every output transfer.
  always @(posedge clk) begin
    crossing_t want, got;
    if (!rst_n) begin
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (in_tvalid && in_tready) crossings_due.push_back(predict_crossing(in_tdata));
      if (out_tvalid && out_tready) begin
        got = {out_tdata[0], out_tdata[32:1], out_tdata[64:33], out_tdata[96:65]};
        if (crossings_due.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected transfer %h", got);
        end else begin
          want = crossings_due.pop_front();
          if (want !== got) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: hit %b/%b x %h/%h y %h/%h col %h/%h",
                       want.hit, got.hit, want.cx, got.cx, want.cy, got.cy,
                       want.col, got.col);
          end
        end
      end
      pending <= crossings_due.size();
    end
  end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the ray against wall intersection
// Drives directed and random ray and wall pairs with random idling on both
// streams and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb;

  localparam int LATENCY = 79;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [287:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  int           fail_count;
  int           pending;
  int           send_idle_pct = 28;
  int           recv_idle_pct = 70;

  always #2 clk = ~clk;

  ray_wall_intersection u_top (.*);

  rwi_checker u_chk (.*);

  // Receiver backpressure.
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return 32'($signed($urandom_range(65536)) - 32768);
      default: return 32'($signed($urandom_range(200)) - 100) <<< 16;
    endcase
  endfunction

  // One input transfer; valid stays high when the next one follows at once.
  task automatic send_pair(logic [31:0] c[9]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {c[8], c[7], c[6], c[5], c[4], c[3], c[2], c[1], c[0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Random pair: mostly a ray through a wall segment, sometimes noise.
  task automatic send_random();
    logic [31:0] c[9];
    logic signed [31:0] a;
    for (int i = 0; i < 9; i++) c[i] = rand_coord();
    if ($urandom_range(9) < 7) begin
      // Aim the ray at a point near the wall, length near the true one.
      a = $signed($urandom_range(200)) - 100;
      c[0] = c[4] - (c[6] - c[4]) * a / 100 + 32'($urandom_range(4000));
      c[1] = c[5] - (c[7] - c[5]) * a / 100 - 32'($urandom_range(4000));
      c[2] = c[4] + (c[6] - c[4]) / 2;
      c[3] = c[5] + (c[7] - c[5]) / 2;
      a = (c[6] - c[4]);
      c[8] = (a[31] ? -a : a) + 32'($urandom_range(8)) * (32'd1 << 14) +
             (c[7][31] ^ c[5][31] ? 32'd0 : 32'($signed(c[7] - c[5]) < 0 ?
              -(c[7] - c[5]) : (c[7] - c[5])));
      if ($urandom_range(9) == 0) c[8] = $urandom;
    end
    send_pair(c);
  endtask

  initial begin
    logic [31:0] c[9];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: simple hit, parallel, degenerate points, extremes.
    c = '{32'h0, 32'hfffb0000, 32'h0, 32'h00050000, 32'hfffe0000, 32'h0,
          32'h00020000, 32'h0, 32'h00040000};
    send_pair(c);
    c = '{32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0, 32'h00010000,
          32'h00050000, 32'h00010000, 32'h00040000};
    send_pair(c);
    c = '{32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000, 32'h0, 32'h0,
          32'h00030000, 32'h00030000, 32'hffffffff};
    send_pair(c);
    c = '{32'h0, 32'h0, 32'h00010000, 32'h00010000, 32'h00020000, 32'h0,
          32'h00020000, 32'h0, 32'hffffffff};
    send_pair(c);
    c = '{32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
          32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'hffffffff};
    send_pair(c);
    c = '{32'h7fffffff, 32'h80000000, 32'h7ffffffe, 32'h80000000, 32'h80000000,
          32'h0, 32'h80000001, 32'h7fffffff, 32'hffffffff};
    send_pair(c);
    c = '{32'h0, 32'h0, 32'h1, 32'h1, 32'h7fff0000, 32'h7fff0000, 32'h7fff0001,
          32'h7fff0000, 32'h0};
    send_pair(c);
    c = '{32'h0, 32'h0, 32'h1, 32'h0, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
          32'h80000000, 32'hffffffff};
    send_pair(c);
    c = '{32'h0, 32'h0, 32'h0, 32'h1, 32'h00030000, 32'h0, 32'h00040000,
          32'h0, 32'h00010000};
    send_pair(c);
    c = '{32'hffffffff, 32'hffffffff, 32'h00010000, 32'h00010000, 32'hfffe0000,
          32'h00020000, 32'h00020000, 32'hfffe0000, 32'h00000001};
    send_pair(c);
    c = '{32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h1, 32'h1, 32'hffffffff, 32'h80000000};
    send_pair(c);

    for (int i = 0; i < 165; i++) send_random();
    // Drain fully once before switching idling pattern.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    send_idle_pct = 70;
    recv_idle_pct = 28;
    for (int i = 0; i < 165; i++) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 170; i++) send_random();
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rwi_pkg.sv
rtl/core/rwi_div.sv
rtl/core/rwi_isqrt.sv
rtl/core/ray_wall_intersection.sv
sim/rwi_checker.sv
sim/tb.sv
